// ===== rtl/rce_pkg.sv =====
package rce_pkg;

   // widths of the datapath and the fields
   localparam int STATE_WIDTH = 32;
   localparam int WORD_W      = 64;
   localparam int COEF_N      = 18;
   localparam int COEF_W      = 16;
   localparam int INFLOW_W    = 16;
   localparam int DIV_BITS    = 51;
   localparam int MUL_STEPS   = 64;
   localparam int RF_DEPTH    = 16;
   localparam int PC_W        = 6;

   localparam logic [PC_W-1:0] UOP_LAST = 6'd55;
   localparam logic [23:0] DT_RESET = 24'd16777;
   localparam logic signed [WORD_W-1:0] ONE_Q24 = 64'sd16777216;
   localparam logic FUNC_RELOAD = 1'b1;

   // saturation limits of the state levels
   localparam logic signed [WORD_W-1:0] SW_MAX = (STATE_WIDTH >= 64) ?
      64'sh7FFF_FFFF_FFFF_FFFF : ((64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [WORD_W-1:0] SW_MIN = -SW_MAX - 64'sd1;

   // configuration register indexes
   localparam logic [2:0] CSR_COEF0 = 3'd0;
   localparam logic [2:0] CSR_COEF1 = 3'd1;
   localparam logic [2:0] CSR_COEF2 = 3'd2;
   localparam logic [2:0] CSR_COEF3 = 3'd3;
   localparam logic [2:0] CSR_COEF4 = 3'd4;
   localparam logic [2:0] CSR_DT    = 3'd5;
   localparam logic [2:0] CSR_INIT  = 3'd6;

   // sequencer operations
   localparam logic [2:0] OP_LDI  = 3'd0;
   localparam logic [2:0] OP_MUL  = 3'd1;
   localparam logic [2:0] OP_ADD  = 3'd2;
   localparam logic [2:0] OP_SUB  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_UPD  = 3'd5;
   localparam logic [2:0] OP_PROD = 3'd6;

   // first operand sources
   localparam logic [1:0] SRC_REG  = 2'd0;
   localparam logic [1:0] SRC_COEF = 2'd1;
   localparam logic [1:0] SRC_DT   = 2'd2;
   localparam logic [1:0] SRC_ONE  = 2'd3;

   // register file slots
   localparam logic [3:0] R_A   = 4'd0;
   localparam logic [3:0] R_B   = 4'd1;
   localparam logic [3:0] R_DA  = 4'd2;
   localparam logic [3:0] R_DB  = 4'd3;
   localparam logic [3:0] R_RES = 4'd4;
   localparam logic [3:0] R_T0  = 4'd5;
   localparam logic [3:0] R_T1  = 4'd6;
   localparam logic [3:0] R_GA  = 4'd7;
   localparam logic [3:0] R_GB  = 4'd8;
   localparam logic [3:0] R_GDA = 4'd9;
   localparam logic [3:0] R_GDB = 4'd10;
   localparam logic [3:0] R_K2R = 4'd11;
   localparam logic [3:0] R_K4R = 4'd12;

   typedef struct packed {
      logic [2:0] op;
      logic [3:0] dst;
      logic [1:0] a_kind;
      logic [4:0] a_idx;
      logic [3:0] b_idx;
      logic       sh24;
   } uop_type;

   function automatic uop_type mk(logic [2:0] op, logic [3:0] dst, logic [1:0] kind,
                                  logic [4:0] a_idx, logic [3:0] b_idx, logic sh24);
      uop_type u;
      u.op = op;
      u.dst = dst;
      u.a_kind = kind;
      u.a_idx = a_idx;
      u.b_idx = b_idx;
      u.sh24 = sh24;
      return u;
   endfunction

   // micro program of one Euler step
   function automatic uop_type uop_at(logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(OP_LDI, R_A,  SRC_REG, 5'd0, R_A, 1'b0);
         6'd1:  u = mk(OP_LDI, R_B,  SRC_REG, 5'd1, R_A, 1'b0);
         6'd2:  u = mk(OP_LDI, R_DA, SRC_REG, 5'd2, R_A, 1'b0);
         6'd3:  u = mk(OP_LDI, R_DB, SRC_REG, 5'd3, R_A, 1'b0);
         6'd4:  u = mk(OP_MUL, R_T0, SRC_COEF, 5'd0, R_A, 1'b0);
         6'd5:  u = mk(OP_ADD, R_T0, SRC_ONE, 5'd0, R_T0, 1'b0);
         6'd6:  u = mk(OP_MUL, R_T1, SRC_COEF, 5'd1, R_B, 1'b0);
         6'd7:  u = mk(OP_ADD, R_T0, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd8:  u = mk(OP_DIV, R_RES, SRC_REG, 5'(R_T0), R_T0, 1'b0);
         6'd9:  u = mk(OP_MUL, R_K2R, SRC_COEF, 5'd2, R_RES, 1'b0);
         6'd10: u = mk(OP_MUL, R_T0, SRC_REG, 5'(R_K2R), R_A, 1'b1);
         6'd11: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd3, R_A, 1'b0);
         6'd12: u = mk(OP_SUB, R_T0, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd13: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd6, R_A, 1'b0);
         6'd14: u = mk(OP_SUB, R_T0, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd15: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd13, R_A, 1'b0);
         6'd16: u = mk(OP_MUL, R_T1, SRC_REG, 5'(R_T1), R_DB, 1'b1);
         6'd17: u = mk(OP_SUB, R_GA, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd18: u = mk(OP_MUL, R_K4R, SRC_COEF, 5'd4, R_RES, 1'b0);
         6'd19: u = mk(OP_MUL, R_T0, SRC_REG, 5'(R_K4R), R_B, 1'b1);
         6'd20: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd5, R_B, 1'b0);
         6'd21: u = mk(OP_SUB, R_T0, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd22: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd9, R_B, 1'b0);
         6'd23: u = mk(OP_SUB, R_T0, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd24: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd12, R_B, 1'b0);
         6'd25: u = mk(OP_MUL, R_T1, SRC_REG, 5'(R_T1), R_DA, 1'b1);
         6'd26: u = mk(OP_SUB, R_GB, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd27: u = mk(OP_MUL, R_T0, SRC_COEF, 5'd7, R_A, 1'b0);
         6'd28: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd8, R_DA, 1'b0);
         6'd29: u = mk(OP_SUB, R_T0, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd30: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd16, R_DA, 1'b0);
         6'd31: u = mk(OP_MUL, R_T1, SRC_REG, 5'(R_T1), R_B, 1'b1);
         6'd32: u = mk(OP_SUB, R_T0, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd33: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd15, R_DA, 1'b0);
         6'd34: u = mk(OP_MUL, R_T1, SRC_REG, 5'(R_T1), R_DB, 1'b1);
         6'd35: u = mk(OP_SUB, R_GDA, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd36: u = mk(OP_MUL, R_T0, SRC_COEF, 5'd10, R_B, 1'b0);
         6'd37: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd11, R_DB, 1'b0);
         6'd38: u = mk(OP_SUB, R_T0, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd39: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd17, R_DB, 1'b0);
         6'd40: u = mk(OP_MUL, R_T1, SRC_REG, 5'(R_T1), R_DA, 1'b1);
         6'd41: u = mk(OP_SUB, R_T0, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd42: u = mk(OP_MUL, R_T1, SRC_COEF, 5'd14, R_A, 1'b0);
         6'd43: u = mk(OP_MUL, R_T1, SRC_REG, 5'(R_T1), R_DB, 1'b1);
         6'd44: u = mk(OP_SUB, R_GDB, SRC_REG, 5'(R_T0), R_T1, 1'b0);
         6'd45: u = mk(OP_MUL, R_T1, SRC_DT, 5'd0, R_GA, 1'b1);
         6'd46: u = mk(OP_UPD, R_A, SRC_REG, 5'(R_A), R_T1, 1'b0);
         6'd47: u = mk(OP_MUL, R_T1, SRC_DT, 5'd0, R_GB, 1'b1);
         6'd48: u = mk(OP_UPD, R_B, SRC_REG, 5'(R_B), R_T1, 1'b0);
         6'd49: u = mk(OP_MUL, R_T1, SRC_DT, 5'd0, R_GDA, 1'b1);
         6'd50: u = mk(OP_UPD, R_DA, SRC_REG, 5'(R_DA), R_T1, 1'b0);
         6'd51: u = mk(OP_MUL, R_T1, SRC_DT, 5'd0, R_GDB, 1'b1);
         6'd52: u = mk(OP_UPD, R_DB, SRC_REG, 5'(R_DB), R_T1, 1'b0);
         6'd53: u = mk(OP_MUL, R_T0, SRC_REG, 5'(R_K2R), R_A, 1'b1);
         6'd54: u = mk(OP_MUL, R_T1, SRC_REG, 5'(R_K4R), R_B, 1'b1);
         default: u = mk(OP_PROD, R_T0, SRC_REG, 5'(R_T0), R_T1, 1'b0);
      endcase
      return u;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_add(logic signed [WORD_W-1:0] a,
                                                        logic signed [WORD_W-1:0] b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end
      return s[WORD_W-1:0];
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_sub(logic signed [WORD_W-1:0] a,
                                                        logic signed [WORD_W-1:0] b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end
      return s[WORD_W-1:0];
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_sw(logic signed [WORD_W-1:0] v);
      if (v > SW_MAX) return SW_MAX;
      if (v < SW_MIN) return SW_MIN;
      return v;
   endfunction

   function automatic logic [31:0] sat32(logic signed [WORD_W-1:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

endpackage

// ===== rtl/rce_mul.sv =====
module rce_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   input  logic        sh24,
   output logic        done,
   output logic signed [63:0] product
);

   logic         busy_ff, busy_in;
   logic         post_ff, post_in;
   logic         done_ff, done_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         neg_ff, neg_in;
   logic         sh_ff, sh_in;
   logic [63:0]  ma_ff, ma_in;
   logic [63:0]  mb_ff, mb_in;
   logic [127:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;

   logic [64:0]  sum;
   logic [127:0] q;
   logic         rem;
   logic         over;
   logic [64:0]  qr;

   // add the multiplicand for one multiplier bit, then shift right
   assign sum = {1'b0, acc_ff[127:64]} + (mb_ff[0] ? {1'b0, ma_ff} : 65'd0);

   // drop fraction bits, round toward minus infinity, saturate
   assign q    = sh_ff ? (acc_ff >> 24) : (acc_ff >> 12);
   assign rem  = sh_ff ? (|acc_ff[23:0]) : (|acc_ff[11:0]);
   assign over = |q[127:63];
   assign qr   = {1'b0, q[63:0]} + {64'd0, rem};

   always_comb begin
      busy_in = busy_ff;
      post_in = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      sh_in   = sh_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         neg_in  = op_a[63] ^ op_b[63];
         sh_in   = sh24;
         ma_in   = op_a[63] ? 64'(-op_a) : op_a;
         mb_in   = op_b[63] ? 64'(-op_b) : op_b;
         acc_in  = 128'd0;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[63:1]};
         mb_in  = {1'b0, mb_ff[63:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(rce_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            post_in = 1'b1;
         end
      end else if (post_ff) begin
         done_in = 1'b1;
         if (!neg_ff) begin
            prod_in = over ? 64'sh7FFF_FFFF_FFFF_FFFF : q[63:0];
         end else if (over || (qr[64:63] != 2'b00)) begin
            prod_in = {1'b1, 63'd0};
         end else begin
            prod_in = 64'(-qr[63:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         post_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         post_ff <= post_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      sh_ff   <= sh_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ===== rtl/rce_div.sv =====
module rce_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [rce_pkg::DIV_BITS-1:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [rce_pkg::DIV_BITS-1:0] quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [rce_pkg::DIV_BITS-1:0] q_ff, q_in;

   logic [63:0] trial;
   logic        ge;

   // restoring division, one quotient bit a cycle
   assign trial = {rem_ff[62:0], q_ff[rce_pkg::DIV_BITS-1]};
   assign ge    = trial >= den_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = 64'd0;
         den_in  = den;
         q_in    = num;
      end else if (busy_ff) begin
         rem_in = ge ? (trial - den_ff) : trial;
         q_in   = {q_ff[rce_pkg::DIV_BITS-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(rce_pkg::DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== rtl/resource_competition_euler_step_core.sv =====
// One forward Euler step of a two-party resource competition per request: the inflow
// sample sets the resources, four derivatives move the asset and defense levels, and
// one result carries production and both new assets. The sequencer runs 56 micro steps
// per request, and the 32 products each pass through a bit-serial multiplier that works
// on one operand bit at a time, with read, start, rounding and write-back steps around
// it; the resource divide is a restoring divide with one quotient bit at a time. After
// reset the level registers are cleared before the first request is taken. A result
// waits in an output register while the next request runs.
module resource_competition_euler_step_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] inflow
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] production, [63:32] asset_a_out,
                                    // [95:64] asset_b_out
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  pc_ff, pc_in;
   logic [1:0]  clr_ff, clr_in;
   logic [15:0] inflow_ff;
   logic        func_ff;
   logic [15:0] coef_ff [rce_pkg::COEF_N];
   logic [23:0] dt_ff;
   logic [63:0] init_ff;
   logic [63:0] rf_mem [rce_pkg::RF_DEPTH];
   logic signed [63:0] rd_a_ff, rd_b_ff;
   logic signed [63:0] na_ff, nb_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff;

   rce_pkg::uop_type uop;
   logic signed [63:0] op_a;
   logic signed [63:0] alu_res;
   logic signed [63:0] init_val;
   logic [15:0] init_field;
   logic        wr_en;
   logic [3:0]  wr_addr;
   logic signed [63:0] wr_data;
   logic        mul_start, mul_done, div_start, div_done, emit, div_skip;
   logic signed [63:0] mul_prod;
   logic [rce_pkg::DIV_BITS-1:0] div_q;

   assign uop = rce_pkg::uop_at(pc_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rce_pkg::COEF_N; i++) coef_ff[i] <= '0;
         dt_ff   <= rce_pkg::DT_RESET;
         init_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            rce_pkg::CSR_COEF0: for (int j = 0; j < 4; j++) coef_ff[j] <= csr_wdata[j*16 +: 16];
            rce_pkg::CSR_COEF1: for (int j = 0; j < 4; j++) coef_ff[4+j] <= csr_wdata[j*16 +: 16];
            rce_pkg::CSR_COEF2: for (int j = 0; j < 4; j++) coef_ff[8+j] <= csr_wdata[j*16 +: 16];
            rce_pkg::CSR_COEF3: for (int j = 0; j < 4; j++) coef_ff[12+j] <= csr_wdata[j*16 +: 16];
            rce_pkg::CSR_COEF4: begin
               coef_ff[16] <= csr_wdata[15:0];
               coef_ff[17] <= csr_wdata[31:16];
            end
            rce_pkg::CSR_DT:   dt_ff <= csr_wdata[23:0];
            rce_pkg::CSR_INIT: init_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pick the first operand
   always_comb begin
      case (uop.a_kind)
         rce_pkg::SRC_COEF: op_a = {48'd0, coef_ff[uop.a_idx]};
         rce_pkg::SRC_DT:   op_a = {40'd0, dt_ff};
         rce_pkg::SRC_ONE:  op_a = rce_pkg::ONE_Q24;
         default:           op_a = rd_a_ff;
      endcase
   end

   // reload value for one level, Q4.12 to Q.24
   always_comb begin
      case (uop.a_idx[1:0])
         2'd0:    init_field = init_ff[15:0];
         2'd1:    init_field = init_ff[31:16];
         2'd2:    init_field = init_ff[47:32];
         default: init_field = init_ff[63:48];
      endcase
      init_val = rce_pkg::sat_sw({{36{init_field[15]}}, init_field, 12'd0});
   end

   // saturating add and subtract
   always_comb begin
      case (uop.op)
         rce_pkg::OP_SUB: alu_res = rce_pkg::sat_sub(op_a, rd_b_ff);
         rce_pkg::OP_UPD: alu_res = rce_pkg::sat_sw(rce_pkg::sat_add(op_a, rd_b_ff));
         default:         alu_res = rce_pkg::sat_add(op_a, rd_b_ff);
      endcase
   end

   assign div_skip = inflow_ff[15] || (inflow_ff == 16'd0) || rd_b_ff[63]
                     || (rd_b_ff == 64'sd0);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      clr_in    = clr_ff;
      wr_en     = 1'b0;
      wr_addr   = uop.dst;
      wr_data   = alu_res;
      mul_start = 1'b0;
      div_start = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = {2'b00, clr_ff};
            wr_data = '0;
            clr_in  = clr_ff + 2'd1;
            if (clr_ff == 2'd3) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            pc_in = '0;
            if (req_tvalid) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            case (uop.op)
               rce_pkg::OP_LDI: begin
                  wr_en    = (func_ff == rce_pkg::FUNC_RELOAD);
                  wr_data  = init_val;
                  pc_in    = pc_ff + 6'd1;
                  state_in = ST_READ;
               end
               rce_pkg::OP_ADD, rce_pkg::OP_SUB, rce_pkg::OP_UPD: begin
                  wr_en    = 1'b1;
                  pc_in    = pc_ff + 6'd1;
                  state_in = ST_READ;
               end
               rce_pkg::OP_MUL: begin
                  mul_start = 1'b1;
                  state_in  = ST_WAIT;
               end
               rce_pkg::OP_DIV: begin
                  if (div_skip) begin
                     wr_en    = 1'b1;
                     wr_data  = '0;
                     pc_in    = pc_ff + 6'd1;
                     state_in = ST_READ;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_WAIT;
                  end
               end
               rce_pkg::OP_PROD: begin
                  if (!rsp_valid_ff || rsp_tready) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_WAIT: begin
            if ((uop.op == rce_pkg::OP_MUL) ? mul_done : div_done) begin
               wr_en    = 1'b1;
               wr_data  = (uop.op == rce_pkg::OP_MUL) ? mul_prod
                          : {{(64 - rce_pkg::DIV_BITS){1'b0}}, div_q};
               pc_in    = pc_ff + 6'd1;
               state_in = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // hold the result until taken
   assign rsp_valid_in = emit | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pc_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture, new asset levels and result payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         inflow_ff <= req_tdata;
         func_ff   <= req_tuser;
      end
      if (state_ff == ST_EXEC && uop.op == rce_pkg::OP_UPD && uop.dst == rce_pkg::R_A) begin
         na_ff <= alu_res;
      end
      if (state_ff == ST_EXEC && uop.op == rce_pkg::OP_UPD && uop.dst == rce_pkg::R_B) begin
         nb_ff <= alu_res;
      end
      if (emit) begin
         rsp_data_ff <= {rce_pkg::sat32(nb_ff), rce_pkg::sat32(na_ff),
                         rce_pkg::sat32(alu_res)};
      end
   end

   // register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) rf_mem[wr_addr] <= wr_data;
      if (state_ff == ST_READ) begin
         rd_a_ff <= rf_mem[uop.a_idx[3:0]];
         rd_b_ff <= rf_mem[uop.b_idx];
      end
   end

   rce_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (op_a),
      .op_b    (rd_b_ff),
      .sh24    (uop.sh24),
      .done    (mul_done),
      .product (mul_prod)
   );

   rce_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({inflow_ff[14:0], 36'd0}),
      .den   (rd_b_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/rce_checker.sv =====
module rce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a new result comes only out of a busy step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without a request");

endmodule

bind resource_competition_euler_step_core rce_checker u_rce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
